// ===== hw/rtl/tdbs_pkg.sv =====
// ----------------------------------------------------------------------------
// tdbs_pkg
// Shared types, command codes, limits and helper functions for the time and
// date button setter.
// ----------------------------------------------------------------------------
package tdbs_pkg;

	// Field widths
	localparam int FIRST_W  = 5;
	localparam int SECOND_W = 6;
	localparam int THIRD_W  = 6;
	localparam int CMD_W    = 3;
	localparam int DIGIT_W  = 4;
	localparam int SEL_W    = 2;
	localparam int PADDR_W  = 3;

	// Command codes
	localparam logic [CMD_W-1:0] CMD_REFRESH = 3'd0;
	localparam logic [CMD_W-1:0] CMD_BLINK   = 3'd1;
	localparam logic [CMD_W-1:0] CMD_NEXT    = 3'd2;
	localparam logic [CMD_W-1:0] CMD_DEC     = 3'd3;
	localparam logic [CMD_W-1:0] CMD_INC     = 3'd4;
	localparam logic [CMD_W-1:0] CMD_LOAD    = 3'd5;

	// Field select codes
	localparam logic [SEL_W-1:0] SEL_FIRST  = 2'd0;
	localparam logic [SEL_W-1:0] SEL_SECOND = 2'd1;
	localparam logic [SEL_W-1:0] SEL_THIRD  = 2'd2;
	localparam logic [SEL_W-1:0] SEL_WRAP   = 2'd3;

	// Register index of the mode register
	localparam logic [0:0] REG_EDIT_DATE = 1'b0;

	// Value limits (6-bit working width)
	localparam logic [5:0] HOUR_TOP   = 6'd23;
	localparam logic [5:0] MINSEC_TOP = 6'd59;
	localparam logic [5:0] MONTH_TOP  = 6'd12;
	localparam logic [5:0] YEAR_TOP   = 6'd40;
	localparam logic [5:0] VAL_ZERO   = 6'd0;
	localparam logic [5:0] VAL_ONE    = 6'd1;

	// Month lengths
	localparam logic [5:0] DAYS_LONG  = 6'd31;
	localparam logic [5:0] DAYS_SHORT = 6'd30;
	localparam logic [5:0] DAYS_LEAP  = 6'd29;
	localparam logic [5:0] DAYS_FEB   = 6'd28;

	localparam logic [DIGIT_W-1:0] BLANK_CODE = 4'd10;

	// Held editor state
	typedef struct packed {
		logic [FIRST_W-1:0]  first;
		logic [SECOND_W-1:0] second;
		logic [THIRD_W-1:0]  third;
		logic [SEL_W-1:0]    sel;
		logic                blank;
	} edit_state_t;

	// One input transaction
	typedef struct packed {
		logic [CMD_W-1:0]    cmd;
		logic [FIRST_W-1:0]  load_first;
		logic [SECOND_W-1:0] load_second;
		logic [THIRD_W-1:0]  load_third;
	} edit_item_t;

	// Days in a month; anything outside 1..12 counts as a long month
	function automatic logic [5:0] month_days(input logic [5:0] month,
			input logic [5:0] year);
		logic [5:0] d;
		case (month)
			6'd2:    d = (year[1:0] == 2'b00) ? DAYS_LEAP : DAYS_FEB;
			6'd4:    d = DAYS_SHORT;
			6'd6:    d = DAYS_SHORT;
			6'd9:    d = DAYS_SHORT;
			6'd11:   d = DAYS_SHORT;
			default: d = DAYS_LONG;
		endcase
		return d;
	endfunction

	// Step up, wrap at top, leave a value above top alone
	function automatic logic [5:0] step_up(input logic [5:0] v,
			input logic [5:0] bottom, input logic [5:0] top);
		logic [5:0] r;
		if (v < top)
			r = v + 6'd1;
		else if (v == top)
			r = bottom;
		else
			r = v;
		return r;
	endfunction

	// Step down, wrap at bottom, leave a value below bottom alone
	function automatic logic [5:0] step_down(input logic [5:0] v,
			input logic [5:0] bottom, input logic [5:0] top);
		logic [5:0] r;
		if (v > bottom)
			r = v - 6'd1;
		else if (v == bottom)
			r = top;
		else
			r = v;
		return r;
	endfunction

	// Tens digit of a value up to 63
	function automatic logic [DIGIT_W-1:0] tens_of(input logic [5:0] v);
		logic [DIGIT_W-1:0] t;
		if (v >= 6'd60)      t = 4'd6;
		else if (v >= 6'd50) t = 4'd5;
		else if (v >= 6'd40) t = 4'd4;
		else if (v >= 6'd30) t = 4'd3;
		else if (v >= 6'd20) t = 4'd2;
		else if (v >= 6'd10) t = 4'd1;
		else                 t = 4'd0;
		return t;
	endfunction

	// Units digit: value minus ten times the tens digit
	function automatic logic [DIGIT_W-1:0] units_of(input logic [5:0] v);
		logic [DIGIT_W-1:0] t;
		logic [6:0]         tt;
		logic [6:0]         u;
		t  = tens_of(v);
		tt = {t, 3'b000} + {2'b00, t, 1'b0};
		u  = {1'b0, v} - tt;
		return u[DIGIT_W-1:0];
	endfunction

endpackage

// ===== hw/rtl/tdbs_edit.sv =====
// ----------------------------------------------------------------------------
// tdbs_edit
// Editor state and its next-state logic: load, field select, blink phase and
// wrapped increment and decrement of the selected value.
// ----------------------------------------------------------------------------
module tdbs_edit (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 edit_date,
	input  logic                 advance,
	input  tdbs_pkg::edit_item_t item,
	output tdbs_pkg::edit_state_t next_state
);
	import tdbs_pkg::*;

	edit_state_t state_q;
	logic [5:0]  first_w;
	logic [5:0]  second_w;
	logic [5:0]  third_w;
	logic [5:0]  days;
	logic [5:0]  first_adj;
	logic [5:0]  second_adj;
	logic [5:0]  third_adj;
	logic        up;
	logic [SEL_W-1:0] sel_inc;

	assign first_w  = {1'b0, state_q.first};
	assign second_w = state_q.second;
	assign third_w  = state_q.third;
	assign days     = month_days(second_w, third_w);
	assign up       = (item.cmd == CMD_INC);
	assign sel_inc  = state_q.sel + 2'd1;

	// Compute the adjusted value for each field under the current mode
	always_comb begin
		if (!edit_date) begin
			first_adj  = up ? step_up(first_w, VAL_ZERO, HOUR_TOP)
			                : step_down(first_w, VAL_ZERO, HOUR_TOP);
			second_adj = up ? step_up(second_w, VAL_ZERO, MINSEC_TOP)
			                : step_down(second_w, VAL_ZERO, MINSEC_TOP);
			third_adj  = up ? step_up(third_w, VAL_ZERO, MINSEC_TOP)
			                : step_down(third_w, VAL_ZERO, MINSEC_TOP);
		end else begin
			first_adj  = up ? step_up(first_w, VAL_ONE, days)
			                : step_down(first_w, VAL_ONE, days);
			second_adj = up ? step_up(second_w, VAL_ONE, MONTH_TOP)
			                : step_down(second_w, VAL_ONE, MONTH_TOP);
			third_adj  = up ? step_up(third_w, VAL_ZERO, YEAR_TOP)
			                : step_down(third_w, VAL_ZERO, YEAR_TOP);
		end
	end

	// Apply the command to the held state
	always_comb begin
		next_state = state_q;
		case (item.cmd)
			CMD_BLINK: begin
				next_state.blank = ~state_q.blank;
			end
			CMD_NEXT: begin
				next_state.sel = (sel_inc == SEL_WRAP) ? SEL_FIRST : sel_inc;
			end
			CMD_DEC, CMD_INC: begin
				case (state_q.sel)
					SEL_FIRST:  next_state.first  = first_adj[FIRST_W-1:0];
					SEL_SECOND: next_state.second = second_adj;
					SEL_THIRD:  next_state.third  = third_adj;
					default:    next_state = state_q;
				endcase
			end
			CMD_LOAD: begin
				next_state.first  = item.load_first;
				next_state.second = item.load_second;
				next_state.third  = item.load_third;
				next_state.sel    = SEL_FIRST;
				next_state.blank  = 1'b0;
			end
			default: begin
				next_state = state_q;
			end
		endcase
	end

	// Commit the new state when a transaction leaves the input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else if (advance) begin
			state_q <= next_state;
		end
	end

endmodule

// ===== hw/rtl/tdbs_digits.sv =====
// ----------------------------------------------------------------------------
// tdbs_digits
// Split the three values into display digit pairs and blank the selected
// pair during the blank phase.
// ----------------------------------------------------------------------------
module tdbs_digits (
	input  tdbs_pkg::edit_state_t      state,
	output logic [tdbs_pkg::DIGIT_W-1:0] digits [6]
);
	import tdbs_pkg::*;

	logic [5:0] vals [3];

	assign vals[0] = {1'b0, state.first};
	assign vals[1] = state.second;
	assign vals[2] = state.third;

	// Tens and units per value, blanked when selected and blinking
	always_comb begin
		for (int k = 0; k < 3; k++) begin
			if (state.blank && (state.sel == SEL_W'(k))) begin
				digits[2*k]   = BLANK_CODE;
				digits[2*k+1] = BLANK_CODE;
			end else begin
				digits[2*k]   = tens_of(vals[k]);
				digits[2*k+1] = units_of(vals[k]);
			end
		end
	end

endmodule

// ===== hw/rtl/time_date_button_setter_core.sv =====
// ----------------------------------------------------------------------------
// time_date_button_setter_core
// Button-driven editor for a clock's time or date with six-digit display out.
// ----------------------------------------------------------------------------
// One transaction in per cycle while not stalled, one result per transaction.
// The input register loads at the accepting edge, one pass through the edit
// and digit-split logic follows, and the result register loads once it is
// free. The block keeps accepting while a result waits, and only stalls when
// both the input stage and the result register are full and the result is
// not being taken. Mode (edit_date at address 0) must be written only while
// no transaction is in flight.
module time_date_button_setter_core (
	input  logic                           clk,
	input  logic                           arst_n,
	// configuration port
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [tdbs_pkg::PADDR_W-1:0]   paddr,
	input  logic [31:0]                    pwdata,
	output logic [31:0]                    prdata,
	output logic                           pready,
	// input channel
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic [tdbs_pkg::CMD_W-1:0]     cmd,
	input  logic [tdbs_pkg::FIRST_W-1:0]   load_first,
	input  logic [tdbs_pkg::SECOND_W-1:0]  load_second,
	input  logic [tdbs_pkg::THIRD_W-1:0]   load_third,
	// output channel
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic [tdbs_pkg::DIGIT_W-1:0]   digit_0,
	output logic [tdbs_pkg::DIGIT_W-1:0]   digit_1,
	output logic [tdbs_pkg::DIGIT_W-1:0]   digit_2,
	output logic [tdbs_pkg::DIGIT_W-1:0]   digit_3,
	output logic [tdbs_pkg::DIGIT_W-1:0]   digit_4,
	output logic [tdbs_pkg::DIGIT_W-1:0]   digit_5
);
	import tdbs_pkg::*;

	logic               edit_date_q;
	logic               s1_valid_q;
	edit_item_t         item_s1;
	logic               out_valid_q;
	logic [DIGIT_W-1:0] digits_q [6];
	logic [DIGIT_W-1:0] digits_w [6];
	edit_state_t        next_state;
	logic               out_free;
	logic               s1_adv;
	logic               cfg_wr;

	// Configuration register
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			edit_date_q <= 1'b0;
		end else if (cfg_wr && (paddr[PADDR_W-1] == REG_EDIT_DATE)) begin
			edit_date_q <= pwdata[0];
		end
	end

	assign prdata = (paddr[PADDR_W-1] == REG_EDIT_DATE) ? {31'd0, edit_date_q} : 32'd0;

	// Handshake control
	assign out_free = !out_valid_q || out_ready;
	assign s1_adv   = s1_valid_q && out_free;
	assign in_ready = !s1_valid_q || out_free;

	// Input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (in_ready) begin
			s1_valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1 <= '{cmd: cmd, load_first: load_first,
			             load_second: load_second, load_third: load_third};
		end
	end

	tdbs_edit u_edit (
		.clk        (clk),
		.arst_n     (arst_n),
		.edit_date  (edit_date_q),
		.advance    (s1_adv),
		.item       (item_s1),
		.next_state (next_state)
	);

	tdbs_digits u_digits (
		.state  (next_state),
		.digits (digits_w)
	);

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= s1_valid_q;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv) begin
			digits_q <= digits_w;
		end
	end

	assign out_valid = out_valid_q;
	assign digit_0   = digits_q[0];
	assign digit_1   = digits_q[1];
	assign digit_2   = digits_q[2];
	assign digit_3   = digits_q[3];
	assign digit_4   = digits_q[4];
	assign digit_5   = digits_q[5];

endmodule

// ===== hw/rtl/tdbs_checker.sv =====
// ----------------------------------------------------------------------------
// tdbs_checker
// Port-level checks for the button setter core, bound to the top level.
// ----------------------------------------------------------------------------
module tdbs_checker (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         in_ready,
	input logic                         out_valid,
	input logic                         out_ready,
	input logic [tdbs_pkg::DIGIT_W-1:0] digit_0,
	input logic [tdbs_pkg::DIGIT_W-1:0] digit_1,
	input logic [tdbs_pkg::DIGIT_W-1:0] digit_2,
	input logic [tdbs_pkg::DIGIT_W-1:0] digit_3,
	input logic [tdbs_pkg::DIGIT_W-1:0] digit_4,
	input logic [tdbs_pkg::DIGIT_W-1:0] digit_5
);
	import tdbs_pkg::*;

	// Hold a stalled result transaction
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(digit_0) && $stable(digit_1)
			&& $stable(digit_2) && $stable(digit_3) && $stable(digit_4)
			&& $stable(digit_5))
		else $error("stalled result changed");

	// An empty result register never blocks input
	a_ready_free: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input stalled with empty output");

	// Blanking covers both digits of a pair
	a_pair_blank: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> ((digit_0 == BLANK_CODE) == (digit_1 == BLANK_CODE))
			&& ((digit_2 == BLANK_CODE) == (digit_3 == BLANK_CODE))
			&& ((digit_4 == BLANK_CODE) == (digit_5 == BLANK_CODE)))
		else $error("half-blanked digit pair");

	// At most one pair blank at a time
	a_one_blank: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> $countones({digit_0 == BLANK_CODE, digit_2 == BLANK_CODE,
			digit_4 == BLANK_CODE}) <= 1)
		else $error("more than one pair blanked");

endmodule

bind time_date_button_setter_core tdbs_checker u_tdbs_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_ready  (in_ready),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.digit_0   (digit_0),
	.digit_1   (digit_1),
	.digit_2   (digit_2),
	.digit_3   (digit_3),
	.digit_4   (digit_4),
	.digit_5   (digit_5)
);

// ===== dv/time_date_button_setter_core_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// time_date_button_setter_core_tb
// Self-checking bench for the time/date button setter. A behavioral model
// tracks the held values, the edit cursor and the blink phase, and predicts
// the six display digits for every button transaction. Directed sequences hit
// the wrap points, month lengths, leap February, out-of-range values and the
// spare command codes. Random phases in both modes follow, with random
// sender gaps and receiver stalls, plus stretches with no idling at all.
// ----------------------------------------------------------------------------
module time_date_button_setter_core_tb;
	import tdbs_pkg::*;

	// Spare command codes; the block treats them as refresh
	localparam logic [CMD_W-1:0] CMD_SPARE_6 = 3'd6;
	localparam logic [CMD_W-1:0] CMD_SPARE_7 = 3'd7;

	// Mode register address and values
	localparam logic [PADDR_W-1:0] MODE_ADDR = {REG_EDIT_DATE, 2'b00};
	localparam logic MODE_TIME = 1'b0;
	localparam logic MODE_DATE = 1'b1;

	// Editing limits
	localparam logic [5:0] HOURS_MAX   = 6'd23;
	localparam logic [5:0] SIXTY_MAX   = 6'd59;
	localparam logic [5:0] MONTHS_MAX  = 6'd12;
	localparam logic [5:0] YEARS_MAX   = 6'd40;

	localparam int CYCLE_LIMIT = 200000;

	typedef logic [5:0][DIGIT_W-1:0] display_t;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                psel = 1'b0;
	logic                penable = 1'b0;
	logic                pwrite = 1'b0;
	logic [PADDR_W-1:0]  paddr = '0;
	logic [31:0]         pwdata = '0;
	logic [31:0]         prdata;
	logic                pready;
	logic                in_valid = 1'b0;
	logic                in_ready;
	logic [CMD_W-1:0]    cmd = CMD_REFRESH;
	logic [FIRST_W-1:0]  load_first = '0;
	logic [SECOND_W-1:0] load_second = '0;
	logic [THIRD_W-1:0]  load_third = '0;
	logic                out_valid;
	logic                out_ready = 1'b0;
	logic [DIGIT_W-1:0]  digit_0;
	logic [DIGIT_W-1:0]  digit_1;
	logic [DIGIT_W-1:0]  digit_2;
	logic [DIGIT_W-1:0]  digit_3;
	logic [DIGIT_W-1:0]  digit_4;
	logic [DIGIT_W-1:0]  digit_5;

	// Model of the editor state
	logic                mode_date = MODE_TIME;
	logic [FIRST_W-1:0]  held_first = '0;
	logic [SECOND_W-1:0] held_second = '0;
	logic [THIRD_W-1:0]  held_third = '0;
	logic [SEL_W-1:0]    cursor = SEL_FIRST;
	logic                blank_on = 1'b0;

	display_t shown_q[$];
	int       mismatch_count = 0;
	int       cycle_count = 0;
	int       in_idle_max = 11;
	int       out_idle_max = 11;

	time_date_button_setter_core dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.psel        (psel),
		.penable     (penable),
		.pwrite      (pwrite),
		.paddr       (paddr),
		.pwdata      (pwdata),
		.prdata      (prdata),
		.pready      (pready),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.cmd         (cmd),
		.load_first  (load_first),
		.load_second (load_second),
		.load_third  (load_third),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.digit_0     (digit_0),
		.digit_1     (digit_1),
		.digit_2     (digit_2),
		.digit_3     (digit_3),
		.digit_4     (digit_4),
		.digit_5     (digit_5)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Abort a hung run
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("status: fail");
			$finish;
		end
	end

	task automatic report_mismatch(input string msg);
		$display("mismatch at %0t: %s", $realtime, msg);
		mismatch_count++;
	endtask

	// Days in a month; February is long every fourth year
	function automatic logic [5:0] days_in_month(input logic [5:0] month,
			input logic [5:0] year);
		if (month == 6'd2)
			return (year % 4 == 0) ? 6'd29 : 6'd28;
		if (month == 6'd4 || month == 6'd6 || month == 6'd9 || month == 6'd11)
			return 6'd30;
		return 6'd31;
	endfunction

	// Step up with wrap; a value above the top is held
	function automatic logic [5:0] wrap_inc(input logic [5:0] v, input logic [5:0] lo,
			input logic [5:0] hi);
		if (v < hi)
			return v + 6'd1;
		return (v == hi) ? lo : v;
	endfunction

	// Step down with wrap; a value below the bottom is held
	function automatic logic [5:0] wrap_dec(input logic [5:0] v, input logic [5:0] lo,
			input logic [5:0] hi);
		if (v > lo)
			return v - 6'd1;
		return (v == lo) ? hi : v;
	endfunction

	// Apply one button transaction to the model and return the display
	function automatic display_t apply_button(input edit_item_t it);
		display_t   shown;
		logic [5:0] v;
		logic [5:0] lo;
		logic [5:0] hi;
		logic [5:0] tens_v;
		logic [5:0] units_v;
		case (it.cmd)
			CMD_BLINK: begin
				blank_on = ~blank_on;
			end
			CMD_NEXT: begin
				cursor = (cursor == SEL_THIRD) ? SEL_FIRST : cursor + 2'd1;
			end
			CMD_DEC, CMD_INC: begin
				v = (cursor == SEL_FIRST) ? {1'b0, held_first} :
					(cursor == SEL_SECOND) ? held_second : held_third;
				lo = 6'd0;
				if (mode_date == MODE_TIME) begin
					hi = (cursor == SEL_FIRST) ? HOURS_MAX : SIXTY_MAX;
				end else if (cursor == SEL_FIRST) begin
					lo = 6'd1;
					hi = days_in_month(held_second, held_third);
				end else if (cursor == SEL_SECOND) begin
					lo = 6'd1;
					hi = MONTHS_MAX;
				end else begin
					hi = YEARS_MAX;
				end
				v = (it.cmd == CMD_INC) ? wrap_inc(v, lo, hi) : wrap_dec(v, lo, hi);
				case (cursor)
					SEL_FIRST:  held_first = v[FIRST_W-1:0];
					SEL_SECOND: held_second = v;
					SEL_THIRD:  held_third = v;
					default: ;
				endcase
			end
			CMD_LOAD: begin
				held_first = it.load_first;
				held_second = it.load_second;
				held_third = it.load_third;
				cursor = SEL_FIRST;
				blank_on = 1'b0;
			end
			default: ;
		endcase

		// Split each value into tens and units, blanking the selected pair
		for (int k = 0; k < 3; k++) begin
			v = (k == 0) ? {1'b0, held_first} : (k == 1) ? held_second : held_third;
			tens_v = v / 6'd10;
			units_v = v % 6'd10;
			if (blank_on && cursor == k[SEL_W-1:0]) begin
				shown[2*k] = BLANK_CODE;
				shown[2*k+1] = BLANK_CODE;
			end else begin
				shown[2*k] = tens_v[DIGIT_W-1:0];
				shown[2*k+1] = units_v[DIGIT_W-1:0];
			end
		end
		return shown;
	endfunction

	// Send one button transaction; called and returns at a rising edge
	task automatic send_item(input logic [CMD_W-1:0] c, input logic [FIRST_W-1:0] f,
			input logic [SECOND_W-1:0] s, input logic [THIRD_W-1:0] t);
		int         gap;
		edit_item_t it;
		gap = $urandom_range(0, in_idle_max);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		cmd <= c;
		load_first <= f;
		load_second <= s;
		load_third <= t;
		@(negedge clk);
		while (!in_ready) @(negedge clk);
		it.cmd = c;
		it.load_first = f;
		it.load_second = s;
		it.load_third = t;
		shown_q.push_back(apply_button(it));
		@(posedge clk);
	endtask

	// Drop valid and hold until every expected display has been taken
	task automatic drain_results();
		in_valid <= 1'b0;
		while (shown_q.size() != 0) @(posedge clk);
		repeat (2) @(posedge clk);
	endtask

	// Write the mode register, then read it back
	task automatic write_mode(input logic v);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= MODE_ADDR;
		pwdata <= {31'd0, v};
		@(posedge clk);
		penable <= 1'b1;
		@(negedge clk);
		while (!pready) @(negedge clk);
		@(posedge clk);
		mode_date = v;
		psel <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
		psel <= 1'b1;
		pwrite <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		@(negedge clk);
		while (!pready) @(negedge clk);
		if (prdata[0] !== v)
			report_mismatch($sformatf("edit_date read %0b, wrote %0b", prdata[0], v));
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	// Mostly near the ends of the range, sometimes anywhere in it
	function automatic logic [5:0] near_limits(input logic [5:0] lo, input logic [5:0] hi);
		case ($urandom_range(0, 2))
			0:       return lo + 6'($urandom_range(0, 2));
			1:       return hi - 6'($urandom_range(0, 2));
			default: return 6'($urandom_range(lo, hi));
		endcase
	endfunction

	// One random button press, loads mostly in range for the current mode
	task automatic random_item();
		int                  pick;
		logic [CMD_W-1:0]    c;
		logic [FIRST_W-1:0]  f;
		logic [SECOND_W-1:0] s;
		logic [THIRD_W-1:0]  t;
		logic [5:0]          day;
		pick = $urandom_range(0, 99);
		f = FIRST_W'($urandom);
		s = SECOND_W'($urandom);
		t = THIRD_W'($urandom);
		if (pick < 12) begin
			c = CMD_LOAD;
			if ($urandom_range(0, 4) != 0) begin
				if (mode_date == MODE_DATE) begin
					day = near_limits(6'd1, 6'd31);
					f = day[FIRST_W-1:0];
					s = near_limits(6'd1, MONTHS_MAX);
					t = near_limits(6'd0, YEARS_MAX);
				end else begin
					day = near_limits(6'd0, HOURS_MAX);
					f = day[FIRST_W-1:0];
					s = near_limits(6'd0, SIXTY_MAX);
					t = near_limits(6'd0, SIXTY_MAX);
				end
			end
		end else if (pick < 24) begin
			c = CMD_NEXT;
		end else if (pick < 48) begin
			c = CMD_INC;
		end else if (pick < 72) begin
			c = CMD_DEC;
		end else if (pick < 82) begin
			c = CMD_BLINK;
		end else begin
			case ($urandom_range(0, 2))
				0:       c = CMD_REFRESH;
				1:       c = CMD_SPARE_6;
				default: c = CMD_SPARE_7;
			endcase
		end
		send_item(c, f, s, t);
	endtask

	// Reset shows all zeros; spare codes only refresh
	task automatic test_reset_state();
		send_item(CMD_SPARE_6, 5'h1f, 6'h3f, 6'h3f);
		send_item(CMD_SPARE_7, 5'h00, 6'h00, 6'h00);
	endtask

	// Hour, minute and second wraps, cursor wrap, blanking, out-of-range values
	task automatic test_time_mode();
		drain_results();
		write_mode(MODE_TIME);
		send_item(CMD_LOAD, 5'd23, 6'd59, 6'd59);
		send_item(CMD_INC, 5'd0, 6'd0, 6'd0);
		send_item(CMD_NEXT, 5'd0, 6'd0, 6'd0);
		send_item(CMD_INC, 5'd0, 6'd0, 6'd0);
		send_item(CMD_NEXT, 5'd0, 6'd0, 6'd0);
		send_item(CMD_INC, 5'd0, 6'd0, 6'd0);
		send_item(CMD_NEXT, 5'd0, 6'd0, 6'd0);
		send_item(CMD_DEC, 5'd0, 6'd0, 6'd0);
		send_item(CMD_BLINK, 5'd0, 6'd0, 6'd0);
		send_item(CMD_LOAD, 5'd31, 6'd63, 6'd63);
		send_item(CMD_INC, 5'd0, 6'd0, 6'd0);
		send_item(CMD_DEC, 5'd0, 6'd0, 6'd0);
	endtask

	// Month lengths, leap February, zero day and month, month and year above top
	task automatic test_date_mode();
		drain_results();
		write_mode(MODE_DATE);
		send_item(CMD_LOAD, 5'd29, 6'd2, 6'd4);
		send_item(CMD_INC, 5'd0, 6'd0, 6'd0);
		send_item(CMD_LOAD, 5'd31, 6'd4, 6'd0);
		send_item(CMD_INC, 5'd0, 6'd0, 6'd0);
		send_item(CMD_DEC, 5'd0, 6'd0, 6'd0);
		send_item(CMD_LOAD, 5'd0, 6'd0, 6'd0);
		send_item(CMD_DEC, 5'd0, 6'd0, 6'd0);
		send_item(CMD_INC, 5'd0, 6'd0, 6'd0);
		send_item(CMD_NEXT, 5'd0, 6'd0, 6'd0);
		send_item(CMD_DEC, 5'd0, 6'd0, 6'd0);
		send_item(CMD_INC, 5'd0, 6'd0, 6'd0);
		send_item(CMD_DEC, 5'd0, 6'd0, 6'd0);
		send_item(CMD_LOAD, 5'd0, 6'd13, 6'd63);
		send_item(CMD_NEXT, 5'd0, 6'd0, 6'd0);
		send_item(CMD_INC, 5'd0, 6'd0, 6'd0);
		send_item(CMD_NEXT, 5'd0, 6'd0, 6'd0);
		send_item(CMD_INC, 5'd0, 6'd0, 6'd0);
		send_item(CMD_DEC, 5'd0, 6'd0, 6'd0);
	endtask

	// Random editing in alternating modes with varied idling; one full drain midway
	task automatic test_random_editing();
		for (int ph = 0; ph < 5; ph++) begin
			drain_results();
			write_mode((ph % 2 == 0) ? MODE_DATE : MODE_TIME);
			in_idle_max = (ph == 1 || ph == 2) ? 0 : 11;
			out_idle_max = (ph == 1 || ph == 3) ? 0 : 11;
			for (int n = 0; n < 100; n++) begin
				if (ph == 4 && n == 50)
					drain_results();
				random_item();
			end
		end
	endtask

	// Take each display transaction and compare it with the oldest prediction
	initial begin : check_results
		int       stall;
		display_t got;
		display_t want;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			stall = $urandom_range(0, out_idle_max);
			if (stall > 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ready <= 1'b1;
			@(negedge clk);
			while (!out_valid) @(negedge clk);
			got = {digit_5, digit_4, digit_3, digit_2, digit_1, digit_0};
			if (shown_q.size() == 0) begin
				report_mismatch("display transaction with none expected");
			end else begin
				want = shown_q.pop_front();
				for (int k = 0; k < 6; k++) begin
					if (got[k] !== want[k])
						report_mismatch($sformatf("digit_%0d got %0d, want %0d",
							k, got[k], want[k]));
				end
			end
			@(posedge clk);
		end
	end

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_state();
		test_time_mode();
		test_date_mode();
		test_random_editing();
		drain_results();
		repeat (8) @(posedge clk);
		if (shown_q.size() != 0)
			report_mismatch($sformatf("%0d displays never arrived", shown_q.size()));
		if (mismatch_count == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule

// ===== files.f =====
hw/rtl/tdbs_pkg.sv
hw/rtl/tdbs_edit.sv
hw/rtl/tdbs_digits.sv
hw/rtl/time_date_button_setter_core.sv
hw/rtl/tdbs_checker.sv
dv/time_date_button_setter_core_tb.sv
